// ===== design/dcpa_pkg.sv =====
// Shared types and constants for the dual channel power averager.
package dcpa_pkg;

    // Fixed field widths of the transfer payloads.
    localparam int CODE_W         = 12;
    localparam int AVG_W          = 16;
    localparam int POWER_W        = 32;
    localparam int COUNT_W        = 32;
    localparam int GAIN_BITS      = 20;
    localparam int GAIN_FRAC_BITS = 16;
    localparam int CFG_INDEX_BITS = 2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_VOLTAGE_GAIN = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CURRENT_GAIN = 2'd1;

    // Gain values after reset (Q4.16).
    localparam logic [GAIN_BITS-1:0] VOLTAGE_GAIN_RESET = 20'd580942;
    localparam logic [GAIN_BITS-1:0] CURRENT_GAIN_RESET = 20'd528129;

    typedef struct packed {
        logic [CODE_W-1:0] voltage_code;
        logic [CODE_W-1:0] current_code;
    } in_item_t;

    typedef struct packed {
        logic [AVG_W-1:0]   avg_voltage_mv;
        logic [AVG_W-1:0]   avg_current_ma;
        logic [POWER_W-1:0] power_uw;
        logic [COUNT_W-1:0] samples_taken;
    } out_item_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } state_t;

    // Step strobes from the sequencer to each lane.
    typedef struct packed {
        logic load;
        logic sum;
        logic mul;
        logic div;
        logic entry_live;
    } lane_ctrl_t;

endpackage

// ===== design/dcpa_ram.sv =====
// Generic single write port RAM with a registered read port.
module dcpa_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 10
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/dcpa_lane.sv =====
// One averaging lane: sample ring, running sum and scaling to engineering units.
module dcpa_lane
    import dcpa_pkg::*;
#(
    parameter int WINDOW    = 10,
    parameter int CODE_BITS = 12
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  lane_ctrl_t                                  ctrl,
    input  logic [((WINDOW > 1) ? $clog2(WINDOW) : 1)-1:0] slot,
    input  logic [CODE_W-1:0]                           code_in,
    input  logic [GAIN_BITS-1:0]                        gain,
    output logic [AVG_W-1:0]                            avg
);

    // Ring width: the code is masked to CODE_BITS low bits.
    localparam int LB        = (CODE_BITS < CODE_W) ? CODE_BITS : CODE_W;
    localparam int SUM_BITS  = $clog2(WINDOW * ((1 << LB) - 1) + 1);
    localparam int PW        = SUM_BITS + GAIN_BITS;
    // Scaled value before the divide by WINDOW; below 2^N when not saturated.
    localparam int WB        = (WINDOW > 1) ? $clog2(WINDOW) : 0;
    localparam int N         = AVG_W + WB;
    localparam int XB        = ((PW - GAIN_FRAC_BITS) > N) ? (PW - GAIN_FRAC_BITS) : (N + 1);
    // Reciprocal of WINDOW, exact for every quotient below 2^N.
    localparam int S         = N + WB;
    localparam longint unsigned MULT = ((64'd1 << S) + WINDOW - 1) / WINDOW;
    localparam int MB        = $clog2(MULT + 1);
    localparam int QB        = ((N + MB) > (S + AVG_W)) ? (N + MB) : (S + AVG_W);
    localparam longint unsigned LIMIT = (64'd1 << AVG_W) * WINDOW;

    logic [LB-1:0]       code_reg;
    logic [SUM_BITS-1:0] sum_reg;
    logic [SUM_BITS-1:0] sum_next;
    logic [PW-1:0]       prod_reg;
    logic [AVG_W-1:0]    avg_reg;
    logic [AVG_W-1:0]    avg_next;
    logic [LB-1:0]       old_code;
    logic [XB-1:0]       scaled;
    logic                sat;
    logic [QB-1:0]       quo;

    // Ring storage for the last WINDOW codes.
    dcpa_ram #(
        .WIDTH (LB),
        .DEPTH (WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (ctrl.sum),
        .waddr (slot),
        .wdata (code_reg),
        .raddr (slot),
        .rdata (old_code)
    );

    // Running sum: drop the oldest code, add the new one.
    always_comb
    begin
        sum_next = sum_reg - (ctrl.entry_live ? SUM_BITS'(old_code) : '0)
                 + SUM_BITS'(code_reg);
    end

    // Divide by WINDOW * 65536 with saturation at the top of the output range.
    always_comb
    begin
        scaled   = XB'(prod_reg[PW-1:GAIN_FRAC_BITS]);
        sat      = (scaled >= XB'(LIMIT));
        quo      = QB'(scaled[N-1:0]) * QB'(MULT);
        avg_next = sat ? '1 : quo[S+AVG_W-1:S];
    end

    // Running sum register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (ctrl.sum)
        begin
            sum_reg <= sum_next;
        end
    end

    // Payload registers along the scaling chain.
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            code_reg <= code_in[LB-1:0];
        end
        if (ctrl.mul)
        begin
            prod_reg <= PW'(sum_reg) * PW'(gain);
        end
        if (ctrl.div)
        begin
            avg_reg <= avg_next;
        end
    end

    assign avg = avg_reg;

endmodule

// ===== design/dcpa_merge.sv =====
// Merging stage: power product of the two lane averages and the output register.
module dcpa_merge
    import dcpa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  logic [AVG_W-1:0]   vavg,
    input  logic [AVG_W-1:0]   iavg,
    input  logic [COUNT_W-1:0] count,
    output logic               full,
    output logic               out_valid,
    input  logic               out_ready,
    output out_item_t          out_data
);

    logic      valid_reg;
    out_item_t data_reg;

    // Output valid: set on load, cleared when the transfer completes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Result payload, power formed from the two averages.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg.avg_voltage_mv <= vavg;
            data_reg.avg_current_ma <= iavg;
            data_reg.power_uw       <= POWER_W'(vavg) * POWER_W'(iavg);
            data_reg.samples_taken  <= count;
        end
    end

    assign full      = valid_reg;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== design/dual_channel_power_averager_core.sv =====
// Top level of the dual channel power averager: sequencer, lanes and merge.
//
// Each accepted sample pair goes from the input transfer to the result
// register through the ring read and running sum update, the gain multiply,
// the reciprocal multiply that divides by WINDOW, and the power multiply in
// the merging stage. A new pair is accepted in the cycle its predecessor's
// result is loaded, so the block takes no new pair while one is in flight;
// the two lanes work side by side and the scaling chain sets the throughput.
// The rings are cleared by per-entry valid bits at reset, so no clearing
// pass is needed and the first WINDOW-1 averages include zero entries.
// Gains must be written through the configuration port while the block is
// idle; the block itself does not enforce this.
module dual_channel_power_averager_core
    import dcpa_pkg::*;
#(
    parameter int WINDOW    = 10,
    parameter int CODE_BITS = 12
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  in_item_t                  in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output out_item_t                 out_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [GAIN_BITS-1:0]      cfg_data
);

    localparam int SLOT_BITS = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    state_t                state_reg;
    state_t                state_next;
    logic [SLOT_BITS-1:0]  slot_reg;
    logic [SLOT_BITS-1:0]  slot_next;
    logic [WINDOW-1:0]     valid_reg;
    logic [COUNT_W-1:0]    count_reg;
    logic [GAIN_BITS-1:0]  vgain_reg;
    logic [GAIN_BITS-1:0]  igain_reg;
    lane_ctrl_t            lane_ctrl;
    logic                  out_full;
    logic                  out_free;
    logic                  accept;
    logic                  merge_load;
    logic [AVG_W-1:0]      vavg;
    logic [AVG_W-1:0]      iavg;

    assign out_free  = !out_full || out_ready;
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:  state_next = ST_MUL;
            ST_MUL:  state_next = ST_DIV;
            ST_DIV:  state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = accept ? ST_SUM : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        in_ready             = 1'b0;
        merge_load           = 1'b0;
        lane_ctrl.sum        = 1'b0;
        lane_ctrl.mul        = 1'b0;
        lane_ctrl.div        = 1'b0;
        unique case (state_reg)
            ST_IDLE: in_ready = 1'b1;
            ST_SUM:  lane_ctrl.sum = 1'b1;
            ST_MUL:  lane_ctrl.mul = 1'b1;
            ST_DIV:  lane_ctrl.div = 1'b1;
            ST_OUT:
            begin
                in_ready   = out_free;
                merge_load = out_free;
            end
            default: in_ready = 1'b0;
        endcase
        lane_ctrl.load       = in_valid && in_ready;
        lane_ctrl.entry_live = valid_reg[slot_reg];
    end

    // Ring write slot wraps after WINDOW entries.
    always_comb
    begin
        slot_next = (slot_reg == SLOT_BITS'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
    end

    // Sequencer state, ring bookkeeping and sample counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            slot_reg  <= '0;
            valid_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (lane_ctrl.sum)
            begin
                valid_reg[slot_reg] <= 1'b1;
                slot_reg            <= slot_next;
            end
        end
    end

    // Gain registers; writes to other indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vgain_reg <= VOLTAGE_GAIN_RESET;
            igain_reg <= CURRENT_GAIN_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_VOLTAGE_GAIN: vgain_reg <= cfg_data;
                CFG_CURRENT_GAIN: igain_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Voltage lane.
    dcpa_lane #(
        .WINDOW    (WINDOW),
        .CODE_BITS (CODE_BITS)
    ) u_vlane (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (lane_ctrl),
        .slot    (slot_reg),
        .code_in (in_data.voltage_code),
        .gain    (vgain_reg),
        .avg     (vavg)
    );

    // Current lane.
    dcpa_lane #(
        .WINDOW    (WINDOW),
        .CODE_BITS (CODE_BITS)
    ) u_ilane (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (lane_ctrl),
        .slot    (slot_reg),
        .code_in (in_data.current_code),
        .gain    (igain_reg),
        .avg     (iavg)
    );

    // Power product and result register.
    dcpa_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (merge_load),
        .vavg      (vavg),
        .iavg      (iavg),
        .count     (count_reg),
        .full      (out_full),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
